// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/asb_pkg.sv =====
// Types and constants of the adaptive spin backoff unit.
package asb_pkg;

  localparam int DATA_W = 16;
  localparam int IDX_W  = 3;

  localparam logic [DATA_W-1:0] LIMIT_RAISE = 16'd100;
  localparam logic [DATA_W-1:0] COUNT_MAX   = 16'hFFFF;

  localparam logic [IDX_W-1:0] REG_SPIN_FLOOR   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SPIN_CEILING = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_SLEEPS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_FIRST_SLEEP  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SLEEP_CAP    = 3'd4;

  localparam logic [DATA_W-1:0] RST_SPIN_FLOOR   = 16'd10;
  localparam logic [DATA_W-1:0] RST_SPIN_CEILING = 16'd1000;
  localparam logic [DATA_W-1:0] RST_MAX_SLEEPS   = 16'd1000;
  localparam logic [DATA_W-1:0] RST_FIRST_SLEEP  = 16'd1;
  localparam logic [DATA_W-1:0] RST_SLEEP_CAP    = 16'd1000;

  typedef enum logic [1:0] {
    ACT_SPIN     = 2'd0,
    ACT_SLEEP    = 2'd1,
    ACT_ACQUIRED = 2'd2,
    ACT_TIMEOUT  = 2'd3
  } asb_action_t;

  typedef struct packed {
    logic [DATA_W-1:0] spin_limit_floor;
    logic [DATA_W-1:0] spin_limit_ceiling;
    logic [DATA_W-1:0] max_sleeps;
    logic [DATA_W-1:0] first_sleep_ms;
    logic [DATA_W-1:0] sleep_cap_ms;
  } asb_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] spin_limit;
    logic [DATA_W-1:0] spins_done;
    logic [DATA_W-1:0] sleeps_done;
    logic [DATA_W-1:0] next_sleep_ms;
    logic              was_contended;
  } asb_state_t;

  typedef struct packed {
    asb_action_t       action;
    logic [DATA_W-1:0] sleep_ms;
    logic [DATA_W-1:0] sleeps_taken;
    logic [DATA_W-1:0] spin_limit_now;
  } asb_result_t;

endpackage

// ===== rtl/asb_cfg_regs.sv =====
// Configuration register file of the adaptive spin backoff unit.
module asb_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [asb_pkg::IDX_W-1:0]      cfg_index,
  input  logic [asb_pkg::DATA_W-1:0]     cfg_data,
  output asb_pkg::asb_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spin_limit_floor   <= asb_pkg::RST_SPIN_FLOOR;
      cfg.spin_limit_ceiling <= asb_pkg::RST_SPIN_CEILING;
      cfg.max_sleeps         <= asb_pkg::RST_MAX_SLEEPS;
      cfg.first_sleep_ms     <= asb_pkg::RST_FIRST_SLEEP;
      cfg.sleep_cap_ms       <= asb_pkg::RST_SLEEP_CAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asb_pkg::REG_SPIN_FLOOR:   cfg.spin_limit_floor   <= cfg_data;
        asb_pkg::REG_SPIN_CEILING: cfg.spin_limit_ceiling <= cfg_data;
        asb_pkg::REG_MAX_SLEEPS:   cfg.max_sleeps         <= cfg_data;
        asb_pkg::REG_FIRST_SLEEP:  cfg.first_sleep_ms     <= cfg_data;
        asb_pkg::REG_SLEEP_CAP:    cfg.sleep_cap_ms       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/asb_step.sv =====
// Next-state and result logic for one lock try.
module asb_step #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          lock_busy,
  input  logic [asb_pkg::DATA_W-1:0]    random_fraction,
  input  asb_pkg::asb_cfg_t             cfg,
  input  asb_pkg::asb_state_t           st,
  output asb_pkg::asb_state_t           st_next,
  output asb_pkg::asb_result_t          res
);

  localparam int FACT_W = FRACTION_BITS + 1;
  localparam int PROD_W = asb_pkg::DATA_W + FACT_W;
  localparam int SHR_W  = PROD_W - FRACTION_BITS;
  localparam int GROW_W = asb_pkg::DATA_W + 2;
  localparam logic [FACT_W-1:0] HALF = FACT_W'(1) << (FRACTION_BITS - 1);

  logic [asb_pkg::DATA_W-1:0] spins_inc;
  logic [asb_pkg::DATA_W-1:0] sleeps_inc;
  logic [asb_pkg::DATA_W-1:0] cur_sleep;
  logic [FACT_W-1:0]          factor;
  logic [PROD_W-1:0]          prod;
  logic [SHR_W-1:0]           prod_shr;
  logic [GROW_W-1:0]          grown;
  logic [asb_pkg::DATA_W-1:0] grown_capped;
  logic [asb_pkg::DATA_W:0]   raised;

  always_comb begin
    spins_inc  = (st.spins_done == asb_pkg::COUNT_MAX) ? st.spins_done
                                                      : st.spins_done + 16'd1;
    sleeps_inc = (st.sleeps_done == asb_pkg::COUNT_MAX) ? st.sleeps_done
                                                       : st.sleeps_done + 16'd1;
    cur_sleep  = (st.next_sleep_ms == '0) ? cfg.first_sleep_ms : st.next_sleep_ms;
    factor     = {1'b0, random_fraction[FRACTION_BITS-1:0]} + HALF;
    prod       = PROD_W'(cur_sleep) * PROD_W'(factor);
    prod_shr   = prod[PROD_W-1:FRACTION_BITS];
    grown      = GROW_W'(cur_sleep) + GROW_W'(prod_shr);
    grown_capped = (grown > GROW_W'(cfg.sleep_cap_ms)) ? cfg.sleep_cap_ms
                                                       : grown[asb_pkg::DATA_W-1:0];
    raised     = {1'b0, st.spin_limit} + {1'b0, asb_pkg::LIMIT_RAISE};
  end

  always_comb begin
    st_next          = st;
    res.action       = asb_pkg::ACT_SPIN;
    res.sleep_ms     = '0;
    res.sleeps_taken = '0;
    if (lock_busy) begin
      st_next.was_contended = 1'b1;
      st_next.spins_done    = spins_inc;
      if (spins_inc >= st.spin_limit) begin
        st_next.spins_done  = '0;
        st_next.sleeps_done = sleeps_inc;
        if (sleeps_inc >= cfg.max_sleeps) begin
          res.action            = asb_pkg::ACT_TIMEOUT;
          res.sleeps_taken      = sleeps_inc;
          st_next.spins_done    = '0;
          st_next.sleeps_done   = '0;
          st_next.next_sleep_ms = '0;
          st_next.was_contended = 1'b0;
        end else begin
          res.action            = asb_pkg::ACT_SLEEP;
          res.sleep_ms          = cur_sleep;
          st_next.next_sleep_ms = grown_capped;
        end
      end
    end else begin
      res.action       = asb_pkg::ACT_ACQUIRED;
      res.sleeps_taken = st.sleeps_done;
      if (st.was_contended) begin
        if (st.sleeps_done == '0) begin
          if (st.spin_limit < cfg.spin_limit_ceiling) begin
            st_next.spin_limit = (raised < {1'b0, cfg.spin_limit_ceiling})
                                 ? raised[asb_pkg::DATA_W-1:0]
                                 : cfg.spin_limit_ceiling;
          end
        end else if (st.spin_limit > cfg.spin_limit_floor) begin
          st_next.spin_limit = st.spin_limit - 16'd1;
        end
      end
      st_next.spins_done    = '0;
      st_next.sleeps_done   = '0;
      st_next.next_sleep_ms = '0;
      st_next.was_contended = 1'b0;
    end
    res.spin_limit_now = st_next.spin_limit;
  end

endmodule

// ===== rtl/adaptive_spin_backoff_unit.sv =====
// Top level of the adaptive spin backoff unit.
// A try is registered at its input transfer, its result when the try fires.
// Throughput: one try per cycle unless res_stall holds the result; the state
// update is a single pass of counter, multiply and clamp logic between input
// and result registers.
// Reset: synchronous; clears both stages, the attempt state and loads defaults.
`include "assert_macros.svh"

module adaptive_spin_backoff_unit #(
  parameter int SPINS_DEFAULT = 100,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [asb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [asb_pkg::DATA_W-1:0]  cfg_data,
  input  logic                        try_valid,
  output logic                        try_stall,
  input  logic                        lock_busy,
  input  logic [asb_pkg::DATA_W-1:0]  random_fraction,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [1:0]                  action,
  output logic [asb_pkg::DATA_W-1:0]  sleep_ms,
  output logic [asb_pkg::DATA_W-1:0]  sleeps_taken,
  output logic [asb_pkg::DATA_W-1:0]  spin_limit_now
);

  asb_pkg::asb_cfg_t    cfg;
  asb_pkg::asb_state_t  st;
  asb_pkg::asb_state_t  st_next;
  asb_pkg::asb_result_t step_res;
  asb_pkg::asb_result_t res;

  logic                       s1_valid;
  logic                       s1_busy;
  logic [asb_pkg::DATA_W-1:0] s1_fraction;
  logic                       advance;
  logic                       fire;
  logic                       attempt_ends;
  logic                       acquire_fires;
  logic                       attempt_open;
  logic                       attempt_clear;

  assign advance   = !(res_valid && res_stall);
  assign try_stall = s1_valid && !advance;
  assign fire      = s1_valid && advance;

  asb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  asb_step #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_step (
    .lock_busy       (s1_busy),
    .random_fraction (s1_fraction),
    .cfg             (cfg),
    .st              (st),
    .st_next         (st_next),
    .res             (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!try_stall) begin
      s1_valid <= try_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (try_valid && !try_stall) begin
      s1_busy     <= lock_busy;
      s1_fraction <= random_fraction;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.spin_limit    <= asb_pkg::DATA_W'(SPINS_DEFAULT);
      st.spins_done    <= '0;
      st.sleeps_done   <= '0;
      st.next_sleep_ms <= '0;
      st.was_contended <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= step_res;
    end
  end

  assign action         = res.action;
  assign sleep_ms       = res.sleep_ms;
  assign sleeps_taken   = res.sleeps_taken;
  assign spin_limit_now = res.spin_limit_now;

  assign attempt_ends  = fire && (step_res.action == asb_pkg::ACT_ACQUIRED ||
                                  step_res.action == asb_pkg::ACT_TIMEOUT);
  assign acquire_fires = fire && step_res.action == asb_pkg::ACT_ACQUIRED;
  assign attempt_open  = res_valid && (res.action == asb_pkg::ACT_SPIN ||
                                       res.action == asb_pkg::ACT_SLEEP);
  assign attempt_clear = st.spins_done == '0 && st.sleeps_done == '0 &&
                         st.next_sleep_ms == '0 && !st.was_contended;

  `ASB_ASSERT_NOW(a_stall_needs_item, try_stall, s1_valid && res_valid)
  `ASB_ASSERT_NOW(a_sleep_only_on_sleep, res_valid && res.action != asb_pkg::ACT_SLEEP, res.sleep_ms == '0)
  `ASB_ASSERT_NOW(a_taken_only_at_end, attempt_open, res.sleeps_taken == '0)
  `ASB_ASSERT_NEXT(a_end_clears_attempt, attempt_ends, attempt_clear)
  `ASB_ASSERT_NEXT(a_limit_moves_on_acquire, !acquire_fires, $stable(st.spin_limit))

endmodule
